[sv/acci_pkg.sv]
package acci_pkg;

  localparam int LBA_BITS = 28;
  localparam int CYL_BITS = 16;

  localparam int START_W  = 28;
  localparam int LBA_W    = (LBA_BITS < START_W) ? LBA_BITS : START_W;
  localparam int PC_W     = 10;
  localparam int STEP_W   = $clog2(LBA_W + 1);
  localparam int CYL_W    = 16;
  localparam int HEAD_W   = 4;
  localparam int HPC_W    = 5;
  localparam int SPT_W    = 6;
  localparam int CFG_W    = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [LBA_W-1:0] CYL_MAX = LBA_W'((64'd1 << CYL_BITS) - 64'd1);

  localparam logic [HPC_W-1:0] HPC_MAX   = HPC_W'(16);
  localparam logic [HPC_W-1:0] HPC_RESET = HPC_W'(16);
  localparam logic [SPT_W-1:0] SPT_RESET = SPT_W'(63);

  localparam logic [CFG_IDX_W-1:0] CFG_HPC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE = 2'd2;

  localparam logic [1:0] CMD_READ_REQ  = 2'd0;
  localparam logic [1:0] CMD_WRITE_REQ = 2'd1;
  localparam logic [1:0] CMD_IRQ       = 2'd2;

  localparam logic [7:0] DRV_MASTER = 8'hA0;
  localparam logic [7:0] DRV_SLAVE  = 8'hB0;
  localparam logic [7:0] ATA_READ   = 8'h20;
  localparam logic [7:0] ATA_WRITE  = 8'h30;

  localparam logic [2:0] OFS_COUNT   = 3'd2;
  localparam logic [2:0] OFS_SECTOR  = 3'd3;
  localparam logic [2:0] OFS_CYL_LO  = 3'd4;
  localparam logic [2:0] OFS_CYL_HI  = 3'd5;
  localparam logic [2:0] OFS_DRVHEAD = 3'd6;
  localparam logic [2:0] OFS_COMMAND = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_CYL,
    ST_DIV_HEAD,
    ST_EMIT_WRITES,
    ST_EMIT_ONE
  } state_t;

  typedef enum logic [2:0] {
    WR_DRVHEAD,
    WR_COUNT,
    WR_SECTOR,
    WR_CYL_LO,
    WR_CYL_HI,
    WR_COMMAND
  } wr_step_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [START_W-1:0] start_block;
    logic [7:0]         block_count;
  } in_item_t;

  typedef struct packed {
    logic [2:0] reg_offset;
    logic [7:0] reg_value;
    logic       write_valid;
    logic       request_done;
    logic       error_flag;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[sv/acci_div.sv]
module acci_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  acci_pkg::div_ctl_t           ctl,
  input  logic [acci_pkg::LBA_W-1:0]   dividend,
  input  logic [acci_pkg::PC_W-1:0]    divisor,
  output acci_pkg::div_stat_t          stat,
  output logic [acci_pkg::LBA_W-1:0]   quotient,
  output logic [acci_pkg::PC_W-1:0]    remainder
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [acci_pkg::STEP_W-1:0]   cnt_r, cnt_nxt;
  logic [acci_pkg::LBA_W-1:0]    quo_r, quo_nxt;
  logic [acci_pkg::PC_W-1:0]     rem_r, rem_nxt;
  logic [acci_pkg::PC_W-1:0]     dsr_r, dsr_nxt;
  logic [acci_pkg::PC_W:0]       trial;
  logic [acci_pkg::PC_W:0]       diff;
  logic                          ge;

  always_comb begin
    trial    = {rem_r, quo_r[acci_pkg::LBA_W-1]};
    ge       = (trial >= {1'b0, dsr_r});
    diff     = trial - {1'b0, dsr_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (ctl.start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = ctl.steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[acci_pkg::PC_W-1:0] : trial[acci_pkg::PC_W-1:0];
      quo_nxt  = {quo_r[acci_pkg::LBA_W-2:0], ge};
      cnt_nxt  = cnt_r - acci_pkg::STEP_W'(1);
      busy_nxt = (cnt_r != acci_pkg::STEP_W'(1));
      done_nxt = (cnt_r == acci_pkg::STEP_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

  a_no_restart_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> !busy_r)
    else $error("divider restarted while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("divider done without a finished run");

endmodule

[sv/acci_out_reg.sv]
module acci_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  acci_pkg::out_item_t push_item,
  output logic                can_push,
  output logic                out_valid,
  input  logic                out_ready,
  output acci_pkg::out_item_t out_data
);

  logic                valid_r, valid_nxt;
  acci_pkg::out_item_t data_r, data_nxt;

  always_comb begin
    can_push  = !valid_r || out_ready;
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (push && can_push) begin
      valid_nxt = 1'b1;
      data_nxt  = push_item;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

[sv/ata_chs_command_issuer.sv]
// Requests are split into cylinder, head and sector before the first register write by the
// bit-serial divider (LBA_BITS steps for the cylinder, 10 steps for head and sector).
// The six writes (or one error result) then leave one per cycle while the output takes them.
// An interrupt during a request gives a single result; one input transfer at a time.
// Reset (rst_n low, synchronous) clears the request state and loads geometry 16/63, master.
module ata_chs_command_issuer (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  acci_pkg::in_item_t                     in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output acci_pkg::out_item_t                    out_data,
  input  logic                                   cfg_we,
  input  logic [acci_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [acci_pkg::CFG_W-1:0]             cfg_wdata
);

  acci_pkg::state_t                state_r, state_nxt;
  acci_pkg::wr_step_t              idx_r, idx_nxt;
  logic [acci_pkg::HPC_W-1:0]      hpc_r;
  logic [acci_pkg::SPT_W-1:0]      spt_r;
  logic                            drive_r;
  logic                            request_active_r, request_active_nxt;
  logic [7:0]                      blocks_requested_r, blocks_requested_nxt;
  logic [7:0]                      blocks_finished_r, blocks_finished_nxt;
  logic                            cmd_write_r, cmd_write_nxt;
  logic [7:0]                      count_r, count_nxt;
  logic [acci_pkg::CYL_W-1:0]      cyl_r, cyl_nxt;
  logic [acci_pkg::HEAD_W-1:0]     head_r, head_nxt;
  logic [acci_pkg::SPT_W-1:0]      sect_r, sect_nxt;
  acci_pkg::out_item_t             one_res_r, one_res_nxt;

  logic [acci_pkg::HPC_W-1:0]      hpc_eff;
  logic [acci_pkg::SPT_W-1:0]      spt_eff;
  logic [acci_pkg::PC_W-1:0]       per_cyl;
  logic                            in_fire;
  logic [7:0]                      fin_inc;

  acci_pkg::div_ctl_t              div_ctl;
  acci_pkg::div_stat_t             div_stat;
  logic [acci_pkg::LBA_W-1:0]      div_dividend;
  logic [acci_pkg::PC_W-1:0]       div_divisor;
  logic [acci_pkg::LBA_W-1:0]      div_quo;
  logic [acci_pkg::PC_W-1:0]       div_rem;

  logic                            push;
  acci_pkg::out_item_t             push_item;
  logic                            can_push;

  acci_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (div_ctl),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  acci_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hpc_r   <= acci_pkg::HPC_RESET;
      spt_r   <= acci_pkg::SPT_RESET;
      drive_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        acci_pkg::CFG_HPC:   hpc_r   <= cfg_wdata[acci_pkg::HPC_W-1:0];
        acci_pkg::CFG_SPT:   spt_r   <= cfg_wdata[acci_pkg::SPT_W-1:0];
        acci_pkg::CFG_DRIVE: drive_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (hpc_r == '0) begin
      hpc_eff = acci_pkg::HPC_W'(1);
    end else if (hpc_r > acci_pkg::HPC_MAX) begin
      hpc_eff = acci_pkg::HPC_MAX;
    end else begin
      hpc_eff = hpc_r;
    end
    spt_eff = (spt_r == '0) ? acci_pkg::SPT_W'(1) : spt_r;
    per_cyl = acci_pkg::PC_W'(hpc_eff) * acci_pkg::PC_W'(spt_eff);
  end

  assign in_ready = (state_r == acci_pkg::ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign fin_inc  = blocks_finished_r + 8'd1;

  always_comb begin
    state_nxt            = state_r;
    idx_nxt              = idx_r;
    request_active_nxt   = request_active_r;
    blocks_requested_nxt = blocks_requested_r;
    blocks_finished_nxt  = blocks_finished_r;
    cmd_write_nxt        = cmd_write_r;
    count_nxt            = count_r;
    cyl_nxt              = cyl_r;
    head_nxt             = head_r;
    sect_nxt             = sect_r;
    one_res_nxt          = one_res_r;
    div_ctl              = '0;
    div_dividend         = in_data.start_block[acci_pkg::LBA_W-1:0];
    div_divisor          = per_cyl;
    push                 = 1'b0;
    push_item            = '0;
    case (state_r)
      acci_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_data.command)
            acci_pkg::CMD_IRQ: begin
              if (request_active_r) begin
                blocks_finished_nxt = fin_inc;
                if (fin_inc == blocks_requested_r) begin
                  request_active_nxt = 1'b0;
                end
                one_res_nxt              = '0;
                one_res_nxt.request_done = (fin_inc == blocks_requested_r);
                one_res_nxt.last         = 1'b1;
                state_nxt                = acci_pkg::ST_EMIT_ONE;
              end
            end
            acci_pkg::CMD_READ_REQ, acci_pkg::CMD_WRITE_REQ: begin
              cmd_write_nxt = (in_data.command == acci_pkg::CMD_WRITE_REQ);
              count_nxt     = in_data.block_count;
              div_ctl.start = 1'b1;
              div_ctl.steps = acci_pkg::STEP_W'(acci_pkg::LBA_W);
              state_nxt     = acci_pkg::ST_DIV_CYL;
            end
            default: ;
          endcase
        end
      end
      acci_pkg::ST_DIV_CYL: begin
        div_dividend = {div_rem, {(acci_pkg::LBA_W - acci_pkg::PC_W){1'b0}}};
        div_divisor  = acci_pkg::PC_W'(spt_eff);
        if (div_stat.done) begin
          if (div_quo > acci_pkg::CYL_MAX) begin
            one_res_nxt            = '0;
            one_res_nxt.error_flag = 1'b1;
            one_res_nxt.last       = 1'b1;
            state_nxt              = acci_pkg::ST_EMIT_ONE;
          end else begin
            cyl_nxt       = div_quo[acci_pkg::CYL_W-1:0];
            div_ctl.start = 1'b1;
            div_ctl.steps = acci_pkg::STEP_W'(acci_pkg::PC_W);
            state_nxt     = acci_pkg::ST_DIV_HEAD;
          end
        end
      end
      acci_pkg::ST_DIV_HEAD: begin
        if (div_stat.done) begin
          head_nxt             = div_quo[acci_pkg::HEAD_W-1:0];
          sect_nxt             = div_rem[acci_pkg::SPT_W-1:0] + acci_pkg::SPT_W'(1);
          request_active_nxt   = 1'b1;
          blocks_requested_nxt = count_r;
          blocks_finished_nxt  = 8'd0;
          idx_nxt              = acci_pkg::WR_DRVHEAD;
          state_nxt            = acci_pkg::ST_EMIT_WRITES;
        end
      end
      acci_pkg::ST_EMIT_WRITES: begin
        push_item.write_valid = 1'b1;
        case (idx_r)
          acci_pkg::WR_DRVHEAD: begin
            push_item.reg_offset = acci_pkg::OFS_DRVHEAD;
            push_item.reg_value  = (drive_r ? acci_pkg::DRV_SLAVE : acci_pkg::DRV_MASTER)
                                   | {4'b0000, head_r};
            if (can_push) idx_nxt = acci_pkg::WR_COUNT;
          end
          acci_pkg::WR_COUNT: begin
            push_item.reg_offset = acci_pkg::OFS_COUNT;
            push_item.reg_value  = count_r;
            if (can_push) idx_nxt = acci_pkg::WR_SECTOR;
          end
          acci_pkg::WR_SECTOR: begin
            push_item.reg_offset = acci_pkg::OFS_SECTOR;
            push_item.reg_value  = {2'b00, sect_r};
            if (can_push) idx_nxt = acci_pkg::WR_CYL_LO;
          end
          acci_pkg::WR_CYL_LO: begin
            push_item.reg_offset = acci_pkg::OFS_CYL_LO;
            push_item.reg_value  = cyl_r[7:0];
            if (can_push) idx_nxt = acci_pkg::WR_CYL_HI;
          end
          acci_pkg::WR_CYL_HI: begin
            push_item.reg_offset = acci_pkg::OFS_CYL_HI;
            push_item.reg_value  = cyl_r[15:8];
            if (can_push) idx_nxt = acci_pkg::WR_COMMAND;
          end
          acci_pkg::WR_COMMAND: begin
            push_item.reg_offset = acci_pkg::OFS_COMMAND;
            push_item.reg_value  = cmd_write_r ? acci_pkg::ATA_WRITE : acci_pkg::ATA_READ;
            push_item.last       = 1'b1;
            if (can_push) state_nxt = acci_pkg::ST_IDLE;
          end
          default: begin
            push_item.write_valid = 1'b0;
            state_nxt             = acci_pkg::ST_IDLE;
          end
        endcase
        push = can_push && push_item.write_valid;
      end
      acci_pkg::ST_EMIT_ONE: begin
        push_item = one_res_r;
        if (can_push) begin
          push      = 1'b1;
          state_nxt = acci_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = acci_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= acci_pkg::ST_IDLE;
      request_active_r   <= 1'b0;
      blocks_requested_r <= 8'd0;
      blocks_finished_r  <= 8'd0;
    end else begin
      state_r            <= state_nxt;
      request_active_r   <= request_active_nxt;
      blocks_requested_r <= blocks_requested_nxt;
      blocks_finished_r  <= blocks_finished_nxt;
    end
    idx_r       <= idx_nxt;
    cmd_write_r <= cmd_write_nxt;
    count_r     <= count_nxt;
    cyl_r       <= cyl_nxt;
    head_r      <= head_nxt;
    sect_r      <= sect_nxt;
    one_res_r   <= one_res_nxt;
  end

  a_request_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_data.command == acci_pkg::CMD_READ_REQ ||
                in_data.command == acci_pkg::CMD_WRITE_REQ)
    |=> state_r == acci_pkg::ST_DIV_CYL && div_stat.busy)
    else $error("request did not start the cylinder division");

  a_div_done_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == acci_pkg::ST_DIV_CYL || state_r == acci_pkg::ST_DIV_HEAD)
    else $error("divider finished outside a division state");

  a_write_last_on_command: assert property (@(posedge clk) disable iff (!rst_n)
    push && state_r == acci_pkg::ST_EMIT_WRITES
    |-> push_item.write_valid && (push_item.last == (idx_r == acci_pkg::WR_COMMAND)))
    else $error("register write sequence marked last at the wrong step");

  a_active_ends_on_irq: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(request_active_r) && $past(rst_n)
    |-> $past(in_fire) && $past(in_data.command) == acci_pkg::CMD_IRQ)
    else $error("request ended without an interrupt");

endmodule

[test/acci_checker.sv]
module acci_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  acci_pkg::in_item_t             in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  acci_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [acci_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [acci_pkg::CFG_W-1:0]     cfg_wdata,
  output int                             fails,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import acci_pkg::*;

  logic [HPC_W-1:0] geo_heads = HPC_RESET;
  logic [SPT_W-1:0] geo_spt   = SPT_RESET;
  logic             drv_slave = 1'b0;

  logic       act_req = 1'b0;
  logic [7:0] blk_req = '0;
  logic [7:0] blk_done = '0;

  out_item_t issued_q[$];

  initial fails = 0;
  initial pending = 0;

  function automatic void push_write(logic [2:0] ofs, logic [7:0] val, logic fin);
    out_item_t r;
    r = '0;
    r.reg_offset  = ofs;
    r.reg_value   = val;
    r.write_valid = 1'b1;
    r.last        = fin;
    issued_q.push_back(r);
  endfunction

  function automatic void issue_taskfile(in_item_t it);
    int unsigned heads, spt, per_cyl, lba, cyl, rest, head, sect;
    out_item_t   r;
    r = '0;
    case (it.command)
      CMD_IRQ: begin
        if (act_req) begin
          blk_done = blk_done + 8'd1;
          r.last = 1'b1;
          if (blk_done == blk_req) begin
            r.request_done = 1'b1;
            act_req = 1'b0;
          end
          issued_q.push_back(r);
        end
      end
      CMD_READ_REQ, CMD_WRITE_REQ: begin
        heads = 32'(geo_heads);
        if (heads == 0) heads = 1;
        if (heads > HPC_MAX) heads = 32'(HPC_MAX);
        spt = 32'(geo_spt);
        if (spt == 0) spt = 1;
        per_cyl = heads * spt;
        lba  = 32'(it.start_block & ((64'd1 << LBA_BITS) - 64'd1));
        cyl  = lba / per_cyl;
        rest = lba % per_cyl;
        head = rest / spt;
        sect = rest % spt + 1;
        if (cyl > CYL_MAX) begin
          r.error_flag = 1'b1;
          r.last       = 1'b1;
          issued_q.push_back(r);
        end else begin
          push_write(OFS_DRVHEAD, (drv_slave ? DRV_SLAVE : DRV_MASTER) | 8'(head), 1'b0);
          push_write(OFS_COUNT, it.block_count, 1'b0);
          push_write(OFS_SECTOR, 8'(sect), 1'b0);
          push_write(OFS_CYL_LO, 8'(cyl), 1'b0);
          push_write(OFS_CYL_HI, 8'(cyl >> 8), 1'b0);
          push_write(OFS_COMMAND, (it.command == CMD_WRITE_REQ) ? ATA_WRITE : ATA_READ, 1'b1);
          act_req  = 1'b1;
          blk_req  = it.block_count;
          blk_done = '0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      geo_heads = HPC_RESET;
      geo_spt   = SPT_RESET;
      drv_slave = 1'b0;
      act_req   = 1'b0;
      blk_req   = '0;
      blk_done  = '0;
      issued_q.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_HPC:   geo_heads = cfg_wdata[HPC_W-1:0];
          CFG_SPT:   geo_spt   = cfg_wdata[SPT_W-1:0];
          CFG_DRIVE: drv_slave = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_valid === 1'b1 && out_ready) begin
        if (issued_q.size() == 0) begin
          $error("unexpected result transfer: %p", out_data);
          fails++;
        end else begin
          want = issued_q.pop_front();
          check_field("reg_offset", 32'(want.reg_offset), 32'(out_data.reg_offset));
          check_field("reg_value", 32'(want.reg_value), 32'(out_data.reg_value));
          check_field("write_valid", 32'(want.write_valid), 32'(out_data.write_valid));
          check_field("request_done", 32'(want.request_done), 32'(out_data.request_done));
          check_field("error_flag", 32'(want.error_flag), 32'(out_data.error_flag));
          check_field("last", 32'(want.last), 32'(out_data.last));
        end
      end
      if (in_valid && in_ready === 1'b1) issue_taskfile(in_data);
      pending <= issued_q.size();
    end
  end

endmodule

[test/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import acci_pkg::*;

  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int SETTLE = 60;
  localparam int DRAIN_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  int fails;
  int pending;

  bit no_idle = 1'b0;
  bit hold_sink = 1'b0;
  int cur_heads = 16;
  int cur_spt = 63;

  ata_chs_command_issuer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  acci_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fails     (fails),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("tb: errors");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(10, 30);
  endfunction

  function automatic in_item_t make_item(logic [1:0] cmd, logic [27:0] lba, logic [7:0] cnt);
    in_item_t it;
    it.command     = cmd;
    it.start_block = lba;
    it.block_count = cnt;
    return it;
  endfunction

  function automatic logic [27:0] pick_lba();
    int unsigned per, bound;
    int r;
    per   = cur_heads * cur_spt;
    bound = per * 65536;
    r = $urandom_range(0, 99);
    if (r < 35) return 28'($urandom_range(0, 65535));
    if (r < 65) begin
      if ($urandom_range(0, 1)) return 28'(bound - 1 - $urandom_range(0, per));
      return 28'(bound + $urandom_range(0, per));
    end
    if (r < 85) return 28'($urandom_range(0, bound - 1));
    return 28'($urandom);
  endfunction

  function automatic logic [7:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 8'($urandom_range(1, 6));
    if (r < 95) return 8'($urandom_range(0, 255));
    return 8'hFF;
  endfunction

  // sink side: random ready, or a long hold when asked
  initial begin
    int gap;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_sink) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_sink = 1'b0;
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  task automatic send(in_item_t it);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic configure(logic [CFG_W-1:0] heads, logic [CFG_W-1:0] spt,
                           logic [CFG_W-1:0] drv);
    cfg_write(CFG_HPC, heads);
    cfg_write(CFG_SPT, spt);
    cfg_write(CFG_DRIVE, drv);
    if ($urandom_range(0, 2) == 0) cfg_write(CFG_SPARE, CFG_W'($urandom));
    cfg_we <= 1'b0;
    cur_heads = int'(heads[HPC_W-1:0]);
    if (cur_heads == 0) cur_heads = 1;
    if (cur_heads > 16) cur_heads = 16;
    cur_spt = (spt == '0) ? 1 : int'(spt);
  endtask

  task automatic run_phase(int n_items);
    int         sent_n;
    int         k;
    logic [1:0] cmd;
    logic [7:0] cnt;
    sent_n = 0;
    while (sent_n < n_items) begin
      if ($urandom_range(0, 99) < 80) begin
        cmd = $urandom_range(0, 1) ? CMD_WRITE_REQ : CMD_READ_REQ;
        cnt = pick_count();
        send(make_item(cmd, pick_lba(), cnt));
        sent_n++;
        k = (cnt != 0 && cnt <= 8 && $urandom_range(0, 3) != 0) ? cnt : $urandom_range(1, 6);
        repeat (k) begin
          send(make_item(CMD_IRQ, 28'($urandom), 8'($urandom)));
          sent_n++;
        end
      end else begin
        send(make_item(2'($urandom_range(0, 3)), 28'($urandom), 8'($urandom)));
        sent_n++;
      end
    end
  endtask

  initial begin
    int waited;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry 16/63, master
    send(make_item(CMD_READ_REQ, 28'd0, 8'd1));
    send(make_item(CMD_IRQ, 28'd0, 8'd0));
    send(make_item(CMD_IRQ, 28'hFFFFFFF, 8'hFF));
    send(make_item(CMD_WRITE_REQ, 28'hFFFFFFF, 8'd1));
    send(make_item(CMD_WRITE_REQ, 28'(65536 * 1008 - 1), 8'd255));
    send(make_item(CMD_READ_REQ, 28'(65536 * 1008), 8'd3));
    send(make_item(CMD_IRQ, 28'd0, 8'd0));
    send(make_item(CMD_READ_REQ, 28'd1007, 8'd2));
    send(make_item(CMD_IRQ, 28'd0, 8'd0));
    send(make_item(CMD_IRQ, 28'd0, 8'd0));
    send(make_item(CMD_SPARE, 28'hFFFFFFF, 8'hFF));
    send(make_item(CMD_IRQ, 28'd0, 8'd0));
    send(make_item(CMD_READ_REQ, 28'd322, 8'd0));
    send(make_item(CMD_IRQ, 28'd0, 8'd0));

    wait_idle();
    configure(6'd0, 6'd0, 6'd1);
    send(make_item(CMD_WRITE_REQ, 28'd65535, 8'd1));
    send(make_item(CMD_WRITE_REQ, 28'd65536, 8'd1));
    send(make_item(CMD_IRQ, 28'd0, 8'd0));

    wait_idle();
    configure(6'd31, 6'd63, 6'd0);
    send(make_item(CMD_READ_REQ, 28'(65536 * 1008 - 1), 8'd4));
    send(make_item(CMD_READ_REQ, 28'hFFFFFFF, 8'd4));
    send(make_item(CMD_IRQ, 28'd0, 8'd0));

    wait_idle();
    configure(6'd1, 6'd1, 6'd0);
    run_phase(8);
    wait_idle();
    configure(6'd16, 6'd63, 6'd1);
    run_phase(8);
    wait_idle();
    configure(6'd63, 6'd0, 6'd0);
    run_phase(8);
    wait_idle();
    configure(6'd0, 6'd63, 6'd1);
    no_idle = 1'b1;
    run_phase(8);
    no_idle = 1'b0;
    repeat (2) begin
      wait_idle();
      configure(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
      run_phase(8);
    end

    // zero count: done only after the finished counter wraps
    wait_idle();
    configure(6'd16, 6'd63, 6'd0);
    send(make_item(CMD_WRITE_REQ, 28'($urandom_range(0, 65535)), 8'd0));
    repeat (256) send(make_item(CMD_IRQ, 28'($urandom), 8'($urandom)));

    // hold the sink so the block backs up into its input
    wait_idle();
    hold_sink = 1'b1;
    no_idle = 1'b1;
    repeat (8) send(make_item(CMD_READ_REQ, pick_lba(), pick_count()));
    no_idle = 1'b0;

    in_valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
